/* design/mofb_pkg.sv */
package mofb_pkg;

  // frame layout
  localparam int FRAME_LEN = 9;
  localparam int IDX_W     = 4;

  localparam logic [7:0]  FRAME_HEADER = 8'hFF;
  localparam logic [7:0]  FRAME_MARKER = 8'h07;
  localparam logic [15:0] CRC_POLY     = 16'hA001;
  localparam logic [15:0] CRC_INIT     = 16'hFFFF;
  localparam logic [7:0]  FLAG_FIXED   = 8'h08;

  // byte positions within the frame
  localparam logic [IDX_W-1:0] POS_HEADER  = 4'd0;
  localparam logic [IDX_W-1:0] POS_MARKER  = 4'd1;
  localparam logic [IDX_W-1:0] POS_LEFT_LO = 4'd2;
  localparam logic [IDX_W-1:0] POS_LEFT_HI = 4'd3;
  localparam logic [IDX_W-1:0] POS_RIGHT_LO = 4'd4;
  localparam logic [IDX_W-1:0] POS_RIGHT_HI = 4'd5;
  localparam logic [IDX_W-1:0] POS_FLAG    = 4'd6;
  localparam logic [IDX_W-1:0] POS_CRC_LO  = 4'd7;
  localparam logic [IDX_W-1:0] POS_CRC_HI  = 4'd8;

  // one command in
  typedef struct packed {
    logic signed [15:0] left_speed;
    logic signed [15:0] right_speed;
  } in_cmd_t;

  // one frame byte out
  typedef struct packed {
    logic [7:0] frame_byte;
    logic       last_byte;
  } out_item_t;

  // reflected crc-16 over one byte, eight shift steps
  function automatic logic [15:0] crc_byte(input logic [15:0] crc_in, input logic [7:0] data);
    logic [15:0] acc;
    acc = crc_in ^ {8'h00, data};
    for (int b = 0; b < 8; b++) begin
      if (acc[0]) begin
        acc = (acc >> 1) ^ CRC_POLY;
      end else begin
        acc = acc >> 1;
      end
    end
    return acc;
  endfunction

endpackage

/* design/motor_order_frame_builder_top.sv */
// a taken command passes from the command register into the frame sender registers before its first byte leaves
// throughput: one byte per cycle while a frame is sent; a second command is
//   held in a one-deep command register while the current frame is sent
// reset (rst_n low at a clock edge) empties both stages and sets speed control to 1
// the receiver cannot stall: each byte is shown for one cycle only
module motor_order_frame_builder_top import mofb_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start,
  output logic      busy,
  input  in_cmd_t   in_cmd,
  output logic      out_valid,
  output out_item_t out_item,
  input  logic      cfg_valid,
  output logic      cfg_ready,
  input  logic      cfg_data
);

  logic             speed_ctrl_r;
  logic             pend_valid_r;
  in_cmd_t          pend_cmd_r;
  logic             active_r;
  logic [IDX_W-1:0] idx_r;
  logic [15:0]      left_r;
  logic [15:0]      right_r;
  logic [7:0]       flag_r;
  logic [15:0]      crc_r;

  logic             accept;
  logic             last_now;
  logic             load;
  logic [7:0]       flag_nxt;
  logic [7:0]       byte_sel;

  // handshakes
  assign cfg_ready = 1'b1;
  assign busy      = pend_valid_r;
  assign accept    = start && !busy;
  assign last_now  = active_r && (idx_r == POS_CRC_HI);
  assign load      = pend_valid_r && (!active_r || last_now);

  // flag byte of the waiting command
  always_comb begin
    flag_nxt    = FLAG_FIXED;
    flag_nxt[7] = speed_ctrl_r;
    flag_nxt[5] = speed_ctrl_r;
    flag_nxt[6] = !pend_cmd_r.left_speed[15] && (|pend_cmd_r.left_speed);
    flag_nxt[4] = !pend_cmd_r.right_speed[15] && (|pend_cmd_r.right_speed);
  end

  // byte select for the current position
  always_comb begin
    case (idx_r)
      POS_HEADER:   byte_sel = FRAME_HEADER;
      POS_MARKER:   byte_sel = FRAME_MARKER;
      POS_LEFT_LO:  byte_sel = left_r[7:0];
      POS_LEFT_HI:  byte_sel = left_r[15:8];
      POS_RIGHT_LO: byte_sel = right_r[7:0];
      POS_RIGHT_HI: byte_sel = right_r[15:8];
      POS_FLAG:     byte_sel = flag_r;
      POS_CRC_LO:   byte_sel = crc_r[7:0];
      POS_CRC_HI:   byte_sel = crc_r[15:8];
      default:      byte_sel = 8'h00;
    endcase
  end

  assign out_valid           = active_r;
  assign out_item.frame_byte = byte_sel;
  assign out_item.last_byte  = last_now;

  // speed control register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      speed_ctrl_r <= 1'b1;
    end else if (cfg_valid && cfg_ready) begin
      speed_ctrl_r <= cfg_data;
    end
  end

  // command holding stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_valid_r <= 1'b0;
    end else if (accept) begin
      pend_valid_r <= 1'b1;
    end else if (load) begin
      pend_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      pend_cmd_r <= in_cmd;
    end
  end

  // frame sender control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= 1'b0;
      idx_r    <= POS_HEADER;
    end else if (load) begin
      active_r <= 1'b1;
      idx_r    <= POS_HEADER;
    end else if (last_now) begin
      active_r <= 1'b0;
      idx_r    <= POS_HEADER;
    end else if (active_r) begin
      idx_r    <= idx_r + 4'd1;
    end
  end

  // frame payload and running crc over marker to flag byte
  always_ff @(posedge clk) begin
    if (load) begin
      left_r  <= pend_cmd_r.left_speed;
      right_r <= pend_cmd_r.right_speed;
      flag_r  <= flag_nxt;
      crc_r   <= CRC_INIT;
    end else if (active_r && (idx_r >= POS_MARKER) && (idx_r <= POS_FLAG)) begin
      crc_r   <= crc_byte(crc_r, byte_sel);
    end
  end

endmodule
